[hw/rtl/aes_pkg.sv]
`timescale 1ns / 1ps

package aes_pkg;

    // Channel payloads.
    typedef struct packed {
        logic        op;
        logic [63:0] block_lo;
        logic [63:0] block_hi;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_lo;
        logic [63:0] result_hi;
    } out_item_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_KEY_SIZE  = 3'd0,
        REG_KEY_WORD0 = 3'd1,
        REG_KEY_WORD1 = 3'd2,
        REG_KEY_WORD2 = 3'd3,
        REG_KEY_WORD3 = 3'd4
    } cfg_reg_t;

    // Operation codes.
    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    // Key sizes.
    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;

    // Round key memory geometry: one 128-bit row per round key.
    localparam int RK_ROWS = 15;
    localparam int RK_AW   = 4;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_PREP,
        ST_ROUND,
        ST_DONE
    } state_t;

    // Write request from the key expander to the round key memory.
    typedef struct packed {
        logic              en;
        logic [RK_AW-1:0]  addr;
        logic [127:0]      data;
    } rk_wr_t;

    // Control of the round datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic first;
        logic last;
        logic dec;
    } rnd_ctl_t;

    typedef logic [7:0] byte_tab_t [256];

    // Multiply by x in GF(2^8) with polynomial 0x11B.
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        return p;
    endfunction

    // S-box built at elaboration: inversion followed by the affine map.
    function automatic byte_tab_t gen_sbox();
        byte_tab_t  t;
        logic [7:0] r;
        logic [7:0] v;
        for (int x = 0; x < 256; x++) begin
            r = 8'h01;
            v = 8'(x);
            for (int e = 0; e < 254; e++) r = gf_mul(r, v);
            if (x == 0) r = 8'h00;
            t[x] = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
                   ^ {r[3:0], r[7:4]} ^ 8'h63;
        end
        return t;
    endfunction

    localparam byte_tab_t SBOX = gen_sbox();

    function automatic byte_tab_t gen_inv_sbox();
        byte_tab_t t;
        for (int x = 0; x < 256; x++) t[SBOX[x]] = 8'(x);
        return t;
    endfunction

    localparam byte_tab_t INV_SBOX = gen_inv_sbox();

endpackage

[hw/rtl/aes_rk_mem.sv]
`timescale 1ns / 1ps

module aes_rk_mem (
    input  logic                 clk,
    input  aes_pkg::rk_wr_t      wr,
    input  logic [aes_pkg::RK_AW-1:0] rd_addr,
    output logic [127:0]         rd_data
);
    import aes_pkg::*;

    logic [127:0] mem [RK_ROWS];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.en) mem[wr.addr] <= wr.data;
        rd_data <= mem[rd_addr];
    end

endmodule

[hw/rtl/aes_key_exp.sv]
`timescale 1ns / 1ps

module aes_key_exp (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [1:0]      ks,
    input  logic [255:0]    key,
    output logic            done,
    output logic            busy,
    output aes_pkg::rk_wr_t wr
);
    import aes_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  wi_reg, wi_next;
    logic [2:0]  mod_reg, mod_next;
    logic [7:0]  rcon_reg, rcon_next;
    logic [31:0] win_reg [8];
    logic [31:0] row_reg [3];
    logic [3:0]  nk;
    logic [5:0]  last_wi;
    logic [31:0] w_prev, w_back, t, t_sub, new_word, key_word;
    logic        last;

    // Key geometry: words in the key and index of the final word.
    always_comb
    begin
        unique case (ks)
            KS_128:  begin nk = 4'd4; last_wi = 6'd43; end
            KS_192:  begin nk = 4'd6; last_wi = 6'd51; end
            default: begin nk = 4'd8; last_wi = 6'd59; end
        endcase
    end

    // One expanded word per cycle.
    always_comb
    begin
        w_prev   = win_reg[0];
        w_back   = win_reg[nk[2:0] - 3'd1];
        key_word = key[32*wi_reg[2:0] +: 32];
        t        = w_prev;
        if (mod_reg == 3'd0) t = {w_prev[7:0], w_prev[31:8]};
        for (int j = 0; j < 4; j++) t_sub[8*j +: 8] = SBOX[t[8*j +: 8]];
        if (mod_reg == 3'd0)
            t_sub[7:0] = t_sub[7:0] ^ rcon_reg;
        else if (!(nk == 4'd8 && mod_reg == 3'd4))
            t_sub = w_prev;
        if (wi_reg < 6'(nk))
            new_word = key_word;
        else
            new_word = w_back ^ t_sub;
    end

    // Counters and round constant.
    always_comb
    begin
        last      = busy_reg && (wi_reg == last_wi);
        busy_next = start ? 1'b1 : (last ? 1'b0 : busy_reg);
        wi_next   = wi_reg;
        mod_next  = mod_reg;
        rcon_next = rcon_reg;
        if (start)
        begin
            wi_next   = '0;
            mod_next  = '0;
            rcon_next = 8'h01;
        end
        else if (busy_reg)
        begin
            wi_next  = wi_reg + 6'd1;
            mod_next = (mod_reg == nk[2:0] - 3'd1) ? 3'd0 : mod_reg + 3'd1;
            if (mod_reg == 3'd0 && wi_reg >= 6'(nk)) rcon_next = xtime(rcon_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            wi_reg   <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
        end
        else
        begin
            busy_reg <= busy_next;
            wi_reg   <= wi_next;
            mod_reg  <= mod_next;
            rcon_reg <= rcon_next;
        end
    end

    // Window of recent words and the row being assembled.
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            win_reg[0] <= new_word;
            for (int j = 1; j < 8; j++) win_reg[j] <= win_reg[j-1];
            if (wi_reg[1:0] != 2'd3) row_reg[wi_reg[1:0]] <= new_word;
        end
    end

    always_comb
    begin
        wr.en   = busy_reg && (wi_reg[1:0] == 2'd3);
        wr.addr = wi_reg[5:2];
        wr.data = {new_word, row_reg[2], row_reg[1], row_reg[0]};
        done    = last;
        busy    = busy_reg;
    end

endmodule

[hw/rtl/aes_round.sv]
`timescale 1ns / 1ps

module aes_round (
    input  logic              clk,
    input  aes_pkg::rnd_ctl_t ctl,
    input  logic [127:0]      block,
    input  logic [127:0]      rkey,
    output logic [127:0]      state
);
    import aes_pkg::*;

    logic [127:0] state_reg, state_next;
    logic [7:0]   s [16];
    logic [7:0]   a [16];
    logic [7:0]   b [16];
    logic [7:0]   c [16];
    logic [7:0]   k [16];
    logic [7:0]   e [16];
    logic [7:0]   d [16];
    logic [7:0]   m [16];

    // One full round per cycle on the byte array.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state_reg[8*i +: 8];
            k[i] = rkey[8*i +: 8];
        end
        // Forward round: SubBytes, ShiftRows, MixColumns, AddRoundKey.
        for (int i = 0; i < 16; i++) a[i] = SBOX[s[i]];
        for (int cc = 0; cc < 4; cc++)
            for (int r = 0; r < 4; r++)
                b[r + 4*cc] = a[r + 4*((cc + r) & 3)];
        for (int cc = 0; cc < 4; cc++)
            for (int r = 0; r < 4; r++)
                m[4*cc + r] = xtime(b[4*cc + r]) ^ xtime(b[4*cc + ((r+1)&3)])
                              ^ b[4*cc + ((r+1)&3)] ^ b[4*cc + ((r+2)&3)]
                              ^ b[4*cc + ((r+3)&3)];
        for (int i = 0; i < 16; i++) e[i] = (ctl.last ? b[i] : m[i]) ^ k[i];
        // Inverse round: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns.
        for (int cc = 0; cc < 4; cc++)
            for (int r = 0; r < 4; r++)
                a[r + 4*cc] = INV_SBOX[s[r + 4*((cc - r) & 3)]];
        for (int i = 0; i < 16; i++) c[i] = a[i] ^ k[i];
        for (int cc = 0; cc < 4; cc++)
            for (int r = 0; r < 4; r++)
                d[4*cc + r] = gf_mul(8'd14, c[4*cc + r])
                              ^ gf_mul(8'd11, c[4*cc + ((r+1)&3)])
                              ^ gf_mul(8'd13, c[4*cc + ((r+2)&3)])
                              ^ gf_mul(8'd9,  c[4*cc + ((r+3)&3)]);
        for (int i = 0; i < 16; i++)
        begin
            if (ctl.first)
                state_next[8*i +: 8] = s[i] ^ k[i];
            else if (ctl.dec)
                state_next[8*i +: 8] = ctl.last ? c[i] : d[i];
            else
                state_next[8*i +: 8] = e[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            state_reg <= block;
        else if (ctl.step)
            state_reg <= state_next;
    end

    assign state = state_reg;

endmodule

[hw/rtl/aes_block_cipher_enc_dec_unit.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Beat
// in       input      in_valid/in_stall   op, block_lo, block_hi
// out      output     out_valid/out_stall result_lo, result_hi
// cfg      input      cfg_we              cfg_index, cfg_wdata
//
// A block passes through nr rounds (nr = 10, 12 or 14) before its result,
// all in the single round unit that runs one AES round per cycle.
// After a key or key-size write the next block first expands the key, one
// word per cycle, into 44, 52 or 60 words.
// The input stalls while a block is in flight; a finished result waits in the
// output register, and the next block is taken meanwhile.
// Reset clears the key registers and marks the round keys as not expanded.

module aes_block_cipher_enc_dec_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  aes_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output aes_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_wdata
);
    import aes_pkg::*;

    state_t       state_reg, state_next;
    logic [1:0]   ks_reg;
    logic [63:0]  key_reg [4];
    logic         ready_reg;
    logic         dec_reg;
    logic [3:0]   step_reg, step_next;
    logic         out_valid_reg;
    out_item_t    out_data_reg;
    logic [1:0]   ks_eff;
    logic [3:0]   nr;
    logic         in_acc, out_free, exp_start, exp_done, exp_busy;
    logic [3:0]   rd_step;
    logic [RK_AW-1:0] rd_addr;
    logic [127:0] rk_data, rnd_state;
    rk_wr_t       rk_wr;
    rnd_ctl_t     ctl;

    assign ks_eff   = (ks_reg == 2'd3) ? KS_256 : ks_reg;
    assign nr       = 4'd10 + {1'b0, ks_eff, 1'b0};
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_acc) state_next = ready_reg ? ST_PREP : ST_EXPAND;
            ST_EXPAND: if (exp_done) state_next = ST_PREP;
            ST_PREP:   state_next = ST_ROUND;
            ST_ROUND:  if (step_reg == nr) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_stall  = 1'b1;
        exp_start = 1'b0;
        ctl       = '0;
        ctl.dec   = dec_reg;
        ctl.first = (step_reg == 4'd0);
        ctl.last  = (step_reg == nr);
        step_next = step_reg;
        rd_step   = step_reg + 4'd1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                ctl.load  = in_acc;
                exp_start = in_acc && !ready_reg;
            end
            ST_PREP:
            begin
                rd_step   = 4'd0;
                step_next = 4'd0;
            end
            ST_ROUND:
            begin
                ctl.step  = 1'b1;
                step_next = step_reg + 4'd1;
            end
            default: ;
        endcase
        if (rd_step > nr)
            rd_addr = '0;
        else
            rd_addr = dec_reg ? nr - rd_step : rd_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            ready_reg     <= 1'b0;
            ks_reg        <= '0;
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (exp_done) ready_reg <= 1'b1;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_KEY_SIZE:  begin ks_reg <= cfg_wdata[1:0]; ready_reg <= 1'b0; end
                    REG_KEY_WORD0: begin key_reg[0] <= cfg_wdata; ready_reg <= 1'b0; end
                    REG_KEY_WORD1: begin key_reg[1] <= cfg_wdata; ready_reg <= 1'b0; end
                    REG_KEY_WORD2: begin key_reg[2] <= cfg_wdata; ready_reg <= 1'b0; end
                    REG_KEY_WORD3: begin key_reg[3] <= cfg_wdata; ready_reg <= 1'b0; end
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc) dec_reg <= (in_data.op == OP_DEC);
        if (state_reg == ST_DONE && out_free)
            out_data_reg <= '{result_lo: rnd_state[63:0], result_hi: rnd_state[127:64]};
    end

    aes_key_exp u_key_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (exp_start),
        .ks    (ks_eff),
        .key   ({key_reg[3], key_reg[2], key_reg[1], key_reg[0]}),
        .done  (exp_done),
        .busy  (exp_busy),
        .wr    (rk_wr)
    );

    aes_rk_mem u_rk_mem (
        .clk     (clk),
        .wr      (rk_wr),
        .rd_addr (rd_addr),
        .rd_data (rk_data)
    );

    aes_round u_round (
        .clk   (clk),
        .ctl   (ctl),
        .block ({in_data.block_hi, in_data.block_lo}),
        .rkey  (rk_data),
        .state (rnd_state)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Expansion only starts when the round keys are stale.
    a_exp_start: assert property (@(posedge clk) disable iff (!rst_n)
        exp_start |-> !ready_reg)
        else $error("key expansion started with valid round keys");

    // Round keys are never marked ready while expansion runs.
    a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        exp_busy |-> !ready_reg)
        else $error("round keys ready during expansion");

    // A result only appears after the final round.
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result shown without a finished block");

    // The input closes right after a beat is taken.
    a_in_close: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("input open while a block is in flight");

endmodule
